@@ rtl/qts_pkg.sv @@
`timescale 1ns / 1ps

package qts_pkg;

    localparam int unsigned IdW        = 32;
    localparam int unsigned MaxResults = 5;
    localparam int unsigned IdxW       = $clog2(MaxResults);

    localparam logic [2:0] VCNT_NONE = 3'd0;
    localparam logic [2:0] VCNT_TRI  = 3'd3;
    localparam logic [2:0] VCNT_QUAD = 3'd4;

    // Slot codes into the working array: corners 0..3, midpoints 4..7
    localparam logic [2:0] S_C0 = 3'd0;
    localparam logic [2:0] S_C1 = 3'd1;
    localparam logic [2:0] S_C2 = 3'd2;
    localparam logic [2:0] S_C3 = 3'd3;
    localparam logic [2:0] S_M0 = 3'd4;
    localparam logic [2:0] S_M1 = 3'd5;
    localparam logic [2:0] S_M2 = 3'd6;
    localparam logic [2:0] S_M3 = 3'd7;

    typedef enum logic [2:0] {
        K_ONE,
        K_OPP,
        K_ADJ,
        K_THREE,
        K_FOUR,
        K_FAIL
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] rot;
    } t_plan;

    typedef struct packed {
        logic [2:0] vcnt;
        logic [2:0] a;
        logic [2:0] b;
        logic [2:0] c;
        logic [2:0] d;
        logic       last;
    } t_shape;

    typedef struct packed {
        logic           ok;
        logic [2:0]     vcnt;
        logic [IdW-1:0] a;
        logic [IdW-1:0] b;
        logic [IdW-1:0] c;
        logic [IdW-1:0] d;
        logic           last;
    } t_elem;

    function automatic t_shape mk_shape(logic [2:0] vcnt, logic [2:0] a, logic [2:0] b,
                                        logic [2:0] c, logic [2:0] d, logic last);
        t_shape s;
        s.vcnt = vcnt;
        s.a    = a;
        s.b    = b;
        s.c    = c;
        s.d    = d;
        s.last = last;
        return s;
    endfunction

    // Sub-element table, indexed by pattern and position within the quad
    function automatic t_shape shape_of(t_kind kind, logic [IdxW-1:0] idx);
        t_shape s;
        s = mk_shape(VCNT_NONE, S_C0, S_C0, S_C0, S_C0, 1'b1);
        case (kind)
            K_ONE: begin
                case (idx)
                    3'd0:    s = mk_shape(VCNT_TRI, S_C0, S_M0, S_C3, S_C0, 1'b0);
                    3'd1:    s = mk_shape(VCNT_TRI, S_C3, S_M0, S_C2, S_C0, 1'b0);
                    default: s = mk_shape(VCNT_TRI, S_C2, S_M0, S_C1, S_C0, 1'b1);
                endcase
            end
            K_OPP: begin
                case (idx)
                    3'd0:    s = mk_shape(VCNT_QUAD, S_C0, S_M0, S_M2, S_C3, 1'b0);
                    default: s = mk_shape(VCNT_QUAD, S_M0, S_C1, S_C2, S_M2, 1'b1);
                endcase
            end
            K_ADJ: begin
                case (idx)
                    3'd0:    s = mk_shape(VCNT_TRI, S_C0, S_M0, S_C3, S_C0, 1'b0);
                    3'd1:    s = mk_shape(VCNT_TRI, S_M0, S_M1, S_C3, S_C0, 1'b0);
                    3'd2:    s = mk_shape(VCNT_TRI, S_M1, S_C2, S_C3, S_C0, 1'b0);
                    default: s = mk_shape(VCNT_TRI, S_M0, S_C1, S_M1, S_C0, 1'b1);
                endcase
            end
            K_THREE: begin
                case (idx)
                    3'd0:    s = mk_shape(VCNT_TRI, S_C0, S_M0, S_M3, S_C0, 1'b0);
                    3'd1:    s = mk_shape(VCNT_TRI, S_M0, S_M1, S_M3, S_C0, 1'b0);
                    3'd2:    s = mk_shape(VCNT_TRI, S_M0, S_C1, S_M1, S_C0, 1'b0);
                    default: s = mk_shape(VCNT_QUAD, S_M3, S_M1, S_C2, S_C3, 1'b1);
                endcase
            end
            K_FOUR: begin
                case (idx)
                    3'd0:    s = mk_shape(VCNT_TRI, S_C0, S_M0, S_M3, S_C0, 1'b0);
                    3'd1:    s = mk_shape(VCNT_TRI, S_M0, S_C1, S_M1, S_C0, 1'b0);
                    3'd2:    s = mk_shape(VCNT_TRI, S_M1, S_C2, S_M2, S_C0, 1'b0);
                    3'd3:    s = mk_shape(VCNT_TRI, S_M2, S_C3, S_M3, S_C0, 1'b0);
                    default: s = mk_shape(VCNT_QUAD, S_M0, S_M1, S_M2, S_M3, 1'b1);
                endcase
            end
            default: s = mk_shape(VCNT_NONE, S_C0, S_C0, S_C0, S_C0, 1'b1);
        endcase
        return s;
    endfunction

endpackage

@@ rtl/qts_decode.sv @@
`timescale 1ns / 1ps

module qts_decode
    import qts_pkg::*;
(
    input  logic [3:0] i_mid_nz,
    input  logic [2:0] i_edge_count,
    output t_plan      o_plan
);

    logic [1:0] first;
    logic [1:0] opp_i;
    logic [1:0] prev_i;

    always_comb begin
        // first refined edge; none present wraps to edge 0
        if (i_mid_nz[0]) begin
            first = 2'd0;
        end else if (i_mid_nz[1]) begin
            first = 2'd1;
        end else if (i_mid_nz[2]) begin
            first = 2'd2;
        end else if (i_mid_nz[3]) begin
            first = 2'd3;
        end else begin
            first = 2'd0;
        end
        opp_i  = first + 2'd2;
        prev_i = first + 2'd3;

        o_plan.kind = K_FAIL;
        o_plan.rot  = 2'd0;
        case (i_edge_count)
            3'd1: begin
                o_plan.kind = K_ONE;
                o_plan.rot  = first;
            end
            3'd2: begin
                if (i_mid_nz[opp_i]) begin
                    o_plan.kind = K_OPP;
                    o_plan.rot  = first;
                end else begin
                    o_plan.kind = K_ADJ;
                    o_plan.rot  = i_mid_nz[prev_i] ? prev_i : first;
                end
            end
            3'd3: begin
                o_plan.kind = K_THREE;
                if (!i_mid_nz[0]) begin
                    o_plan.rot = 2'd2;
                end else if (!i_mid_nz[1]) begin
                    o_plan.rot = 2'd3;
                end else if (!i_mid_nz[3]) begin
                    o_plan.rot = 2'd1;
                end else begin
                    o_plan.rot = 2'd0;
                end
            end
            3'd4: begin
                o_plan.kind = K_FOUR;
                o_plan.rot  = 2'd0;
            end
            default: begin
                o_plan.kind = K_FAIL;
                o_plan.rot  = 2'd0;
            end
        endcase
    end

endmodule

@@ rtl/qts_select.sv @@
`timescale 1ns / 1ps

module qts_select
    import qts_pkg::*;
(
    input  logic [IdW-1:0]  i_corner [4],
    input  logic [IdW-1:0]  i_mid    [4],
    input  t_plan           i_plan,
    input  logic [IdxW-1:0] i_idx,
    output t_elem           o_elem
);

    logic [IdW-1:0] wc [4];
    logic [IdW-1:0] wm [4];
    t_shape         shp;

    function automatic logic [IdW-1:0] pick(logic [2:0] s, logic [IdW-1:0] c [4],
                                            logic [IdW-1:0] m [4]);
        return s[2] ? m[s[1:0]] : c[s[1:0]];
    endfunction

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            wc[i] = i_corner[2'(i) + i_plan.rot];
            wm[i] = i_mid[2'(i) + i_plan.rot];
        end
        shp = shape_of(i_plan.kind, i_idx);

        if (i_plan.kind == K_FAIL) begin
            o_elem = '0;
            o_elem.last = 1'b1;
        end else begin
            o_elem.ok   = 1'b1;
            o_elem.vcnt = shp.vcnt;
            o_elem.a    = pick(shp.a, wc, wm);
            o_elem.b    = pick(shp.b, wc, wm);
            o_elem.c    = pick(shp.c, wc, wm);
            o_elem.d    = (shp.vcnt == VCNT_QUAD) ? pick(shp.d, wc, wm) : '0;
            o_elem.last = shp.last;
        end
    end

endmodule

@@ rtl/quad_transition_splitter_core.sv @@
`timescale 1ns / 1ps

// Splits one quad into 2 to 5 transition sub-elements (triangles or quads),
// or a single ok=0 result for an edge count outside 1..4. The refinement
// pattern and rotation are decoded as the quad is taken into the input
// register; from there one sub-element per cycle, while the output is not
// stalled, is selected into the output register, so a quad holds the input
// register until its last result (1 to 5 in all) is loaded, and the next quad
// is taken in the cycle its last result is loaded. A quad gives 5 results
// with four refined edges, 2 to 4 for the other patterns, 1 for a failure. A
// first result goes through the input register, then the output register.
module quad_transition_splitter_core
    import qts_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [31:0]    i_corner_0,
    input  logic [31:0]    i_corner_1,
    input  logic [31:0]    i_corner_2,
    input  logic [31:0]    i_corner_3,
    input  logic [31:0]    i_mid_0,
    input  logic [31:0]    i_mid_1,
    input  logic [31:0]    i_mid_2,
    input  logic [31:0]    i_mid_3,
    input  logic [2:0]     i_edge_count,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_ok,
    output logic [2:0]     o_vertex_count,
    output logic [31:0]    o_vert_a,
    output logic [31:0]    o_vert_b,
    output logic [31:0]    o_vert_c,
    output logic [31:0]    o_vert_d,
    output logic           o_last
);

    logic [3:0]      mid_nz;
    t_plan           n_plan;
    t_elem           elem;
    logic            in_xfer;
    logic            out_load;

    logic            r_in_valid;
    logic [IdW-1:0]  r_corner [4];
    logic [IdW-1:0]  r_mid    [4];
    t_plan           r_plan;
    logic [IdxW-1:0] r_idx;
    logic            r_out_valid;
    t_elem           r_out;

    assign mid_nz = {i_mid_3 != '0, i_mid_2 != '0, i_mid_1 != '0, i_mid_0 != '0};

    qts_decode u_decode (
        .i_mid_nz     (mid_nz),
        .i_edge_count (i_edge_count),
        .o_plan       (n_plan)
    );

    qts_select u_select (
        .i_corner (r_corner),
        .i_mid    (r_mid),
        .i_plan   (r_plan),
        .i_idx    (r_idx),
        .o_elem   (elem)
    );

    assign out_load   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || (out_load && elem.last);
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (out_load && elem.last) begin
                r_in_valid <= 1'b0;
            end

            // advance through the sub-elements, restart on the last one
            if (out_load) begin
                r_idx <= elem.last ? '0 : r_idx + 1'b1;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_corner <= '{i_corner_0, i_corner_1, i_corner_2, i_corner_3};
            r_mid    <= '{i_mid_0, i_mid_1, i_mid_2, i_mid_3};
            r_plan   <= n_plan;
        end
        if (out_load) begin
            r_out <= elem;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_ok           = r_out.ok;
    assign o_vertex_count = r_out.vcnt;
    assign o_vert_a       = r_out.a;
    assign o_vert_b       = r_out.b;
    assign o_vert_c       = r_out.c;
    assign o_vert_d       = r_out.d;
    assign o_last         = r_out.last;

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> r_idx == '0)
        else $error("sub-element index not at start while input register empty");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> r_idx < IdxW'(MaxResults))
        else $error("sub-element index out of range");

    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !elem.last) |=> r_in_valid && r_idx == $past(r_idx) + 1'b1)
        else $error("quad dropped before its last sub-element");

    a_fail_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.ok) |-> (r_out.last && r_out.vcnt == VCNT_NONE))
        else $error("failure result not a single empty last result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid && $stable(r_out))
        else $error("stalled result changed");

endmodule
